// ===== design/lock_registry_held_stack_macros.svh =====
// ----------------------------------------------------------------------------
// lock_registry_held_stack_macros
// assertion macros used by the checker of the lock registry block
// ----------------------------------------------------------------------------
`ifndef LOCK_REGISTRY_HELD_STACK_MACROS_SVH
`define LOCK_REGISTRY_HELD_STACK_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LRHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrhs assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LRHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrhs assertion failed");

`endif

// ===== design/lrhs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrhs_pkg
// sizes, codes and sequencer states of the lock registry and held stack
// ----------------------------------------------------------------------------
`default_nettype none

package lrhs_pkg;

	localparam int MAX_LOCKS = 256;
	localparam int MAX_HELD  = 32;

	localparam int ADDR_W    = 64;
	localparam int LOCK_ID_W = 8;
	localparam int STATUS_W  = 3;
	localparam int DEPTH_W   = 6;

	localparam int ID_W   = $clog2(MAX_LOCKS);
	localparam int RCNT_W = $clog2(MAX_LOCKS + 1);
	localparam int HIDX_W = $clog2(MAX_HELD);
	localparam int HCNT_W = $clog2(MAX_HELD + 1);

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_REG_FULL = 3'd1,
		STAT_OVERFLOW = 3'd2,
		STAT_UNKNOWN  = 3'd3,
		STAT_NOT_HELD = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_HSCAN,
		ST_SHIFT,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// ===== design/lock_registry_held_stack.sv =====
// ----------------------------------------------------------------------------
// lock_registry_held_stack
// lock registry with dense ids and a single-thread held-lock stack
// ----------------------------------------------------------------------------
// One word in, one word out. An acquire or release word is taken only while
// the sequencer is idle; it then walks the registry memory one entry per
// cycle through its single read port, decides, and for a release walks the
// held stack from the top and moves the entries above the match down one
// by one. The result sits in an output register, so a new word is taken
// while the previous result still waits. Both stores are written before
// they are read, so they need no clearing after reset. Registry full and
// unknown lock report id zero; a stack overflow still registers a new
// address.
// ----------------------------------------------------------------------------
`default_nettype none

module lock_registry_held_stack (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             opcode,
	input  wire logic [lrhs_pkg::ADDR_W-1:0]      lock_address,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [lrhs_pkg::LOCK_ID_W-1:0]   lock_id,
	output logic      [lrhs_pkg::STATUS_W-1:0]    status,
	output logic      [lrhs_pkg::DEPTH_W-1:0]     held_depth
);

	import lrhs_pkg::*;

	// sequencer and bookkeeping
	state_t              state_q, state_d;
	logic [RCNT_W-1:0]   reg_cnt_q, reg_cnt_d;     // registered locks
	logic [HCNT_W-1:0]   held_cnt_q, held_cnt_d;   // held stack depth
	logic [RCNT_W-1:0]   scan_q, scan_d;           // next registry entry to read
	logic [HCNT_W-1:0]   hk_q, hk_d;               // held stack search pointer
	logic [HCNT_W-1:0]   sh_q, sh_d;               // next stack entry to move down
	logic                pend_s1, pend_d;          // a memory read is in flight
	logic                out_valid_q, out_valid_d;

	// per-item payload
	logic                op_q, op_d;
	logic [ADDR_W-1:0]   addr_q, addr_d;
	logic [ID_W-1:0]     id_q, id_d;
	logic                hit_q, hit_d;
	status_t             stat_q, stat_d;
	logic [ID_W-1:0]     ridx_s1, ridx_d;          // registry index of the read in flight
	logic [HIDX_W-1:0]   hidx_s1, hidx_d;          // stack index of the read in flight

	// output register
	logic [LOCK_ID_W-1:0] out_id_q;
	status_t              out_stat_q;
	logic [DEPTH_W-1:0]   out_depth_q;
	logic                 out_load;

	// registry memory, addresses by id
	logic [ADDR_W-1:0]   reg_mem [MAX_LOCKS];
	logic [ADDR_W-1:0]   reg_rd_q;
	logic                reg_re, reg_we;
	logic [ID_W-1:0]     reg_raddr, reg_waddr;

	// held stack memory, ids bottom first
	logic [ID_W-1:0]     held_mem [MAX_HELD];
	logic [ID_W-1:0]     held_rd_q;
	logic                held_re, held_we;
	logic [HIDX_W-1:0]   held_raddr, held_waddr;
	logic [ID_W-1:0]     held_wdata;

	logic [HCNT_W-1:0]   hk_m1;
	logic [ID_W-1:0]     new_id;

	assign hk_m1  = hk_q - HCNT_W'(1);
	assign new_id = hit_q ? id_q : reg_cnt_q[ID_W-1:0];

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign lock_id    = out_id_q;
	assign status     = out_stat_q;
	assign held_depth = out_depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			reg_cnt_q   <= '0;
			held_cnt_q  <= '0;
			scan_q      <= '0;
			hk_q        <= '0;
			sh_q        <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			reg_cnt_q   <= reg_cnt_d;
			held_cnt_q  <= held_cnt_d;
			scan_q      <= scan_d;
			hk_q        <= hk_d;
			sh_q        <= sh_d;
			pend_s1     <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		op_q    <= op_d;
		addr_q  <= addr_d;
		id_q    <= id_d;
		hit_q   <= hit_d;
		stat_q  <= stat_d;
		ridx_s1 <= ridx_d;
		hidx_s1 <= hidx_d;
		if (out_load) begin
			out_id_q    <= LOCK_ID_W'(id_q);
			out_stat_q  <= stat_q;
			out_depth_q <= DEPTH_W'(held_cnt_q);
		end
	end

	// registry memory, one read and one write port
	always_ff @(posedge clk) begin
		if (reg_we)
			reg_mem[reg_waddr] <= addr_q;
		if (reg_re)
			reg_rd_q <= reg_mem[reg_raddr];
	end

	// held stack memory, one read and one write port
	always_ff @(posedge clk) begin
		if (held_we)
			held_mem[held_waddr] <= held_wdata;
		if (held_re)
			held_rd_q <= held_mem[held_raddr];
	end

	// next state, memory strobes and register updates
	always_comb begin
		state_d     = state_q;
		reg_cnt_d   = reg_cnt_q;
		held_cnt_d  = held_cnt_q;
		scan_d      = scan_q;
		hk_d        = hk_q;
		sh_d        = sh_q;
		pend_d      = pend_s1;
		op_d        = op_q;
		addr_d      = addr_q;
		id_d        = id_q;
		hit_d       = hit_q;
		stat_d      = stat_q;
		ridx_d      = ridx_s1;
		hidx_d      = hidx_s1;
		out_load    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		reg_re      = 1'b0;
		reg_raddr   = '0;
		reg_we      = 1'b0;
		reg_waddr   = '0;
		held_re     = 1'b0;
		held_raddr  = '0;
		held_we     = 1'b0;
		held_waddr  = '0;
		held_wdata  = '0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_d    = opcode;
					addr_d  = lock_address;
					id_d    = '0;
					stat_d  = STAT_OK;
					scan_d  = '0;
					pend_d  = 1'b0;
					state_d = ST_SCAN;
				end
			end

			// read one registry entry per cycle, compare the one read last cycle
			ST_SCAN: begin
				if (pend_s1 && reg_rd_q == addr_q) begin
					id_d    = ridx_s1;
					hit_d   = 1'b1;
					pend_d  = 1'b0;
					state_d = ST_DECIDE;
				end else if (!pend_s1 && scan_q == reg_cnt_q) begin
					hit_d   = 1'b0;
					state_d = ST_DECIDE;
				end else if (scan_q != reg_cnt_q) begin
					reg_re    = 1'b1;
					reg_raddr = scan_q[ID_W-1:0];
					ridx_d    = scan_q[ID_W-1:0];
					scan_d    = scan_q + RCNT_W'(1);
					pend_d    = 1'b1;
				end else begin
					pend_d = 1'b0;
				end
			end

			ST_DECIDE: begin
				if (op_q == OP_ACQUIRE) begin
					if (!hit_q && reg_cnt_q == RCNT_W'(MAX_LOCKS)) begin
						stat_d = STAT_REG_FULL;
						id_d   = '0;
					end else begin
						id_d = new_id;
						if (!hit_q) begin
							reg_we    = 1'b1;
							reg_waddr = reg_cnt_q[ID_W-1:0];
							reg_cnt_d = reg_cnt_q + RCNT_W'(1);
						end
						if (held_cnt_q == HCNT_W'(MAX_HELD)) begin
							stat_d = STAT_OVERFLOW;
						end else begin
							held_we    = 1'b1;
							held_waddr = held_cnt_q[HIDX_W-1:0];
							held_wdata = new_id;
							held_cnt_d = held_cnt_q + HCNT_W'(1);
						end
					end
					state_d = ST_RESP;
				end else begin
					if (!hit_q) begin
						stat_d  = STAT_UNKNOWN;
						id_d    = '0;
						state_d = ST_RESP;
					end else begin
						hk_d    = held_cnt_q;
						pend_d  = 1'b0;
						state_d = ST_HSCAN;
					end
				end
			end

			// search the held stack from the top
			ST_HSCAN: begin
				if (pend_s1 && held_rd_q == id_q) begin
					sh_d    = HCNT_W'(hidx_s1) + HCNT_W'(1);
					pend_d  = 1'b0;
					state_d = ST_SHIFT;
				end else if (!pend_s1 && hk_q == '0) begin
					stat_d  = STAT_NOT_HELD;
					state_d = ST_RESP;
				end else if (hk_q != '0) begin
					held_re    = 1'b1;
					held_raddr = hk_m1[HIDX_W-1:0];
					hidx_d     = hk_m1[HIDX_W-1:0];
					hk_d       = hk_m1;
					pend_d     = 1'b1;
				end else begin
					pend_d = 1'b0;
				end
			end

			// close the gap: read entry j+1, write it to j next cycle
			ST_SHIFT: begin
				if (pend_s1) begin
					held_we    = 1'b1;
					held_waddr = hidx_s1 - HIDX_W'(1);
					held_wdata = held_rd_q;
				end
				if (sh_q != held_cnt_q) begin
					held_re    = 1'b1;
					held_raddr = sh_q[HIDX_W-1:0];
					hidx_d     = sh_q[HIDX_W-1:0];
					sh_d       = sh_q + HCNT_W'(1);
					pend_d     = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_s1) begin
						held_cnt_d = held_cnt_q - HCNT_W'(1);
						state_d    = ST_RESP;
					end
				end
			end

			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/lrhs_checker.sv =====
// ----------------------------------------------------------------------------
// lrhs_checker
// port-level checks of the lock registry block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "lock_registry_held_stack_macros.svh"

module lrhs_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             opcode,
	input wire logic [lrhs_pkg::ADDR_W-1:0]      lock_address,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [lrhs_pkg::LOCK_ID_W-1:0]   lock_id,
	input wire logic [lrhs_pkg::STATUS_W-1:0]    status,
	input wire logic [lrhs_pkg::DEPTH_W-1:0]     held_depth
);

	import lrhs_pkg::*;

	logic unused_in;
	assign unused_in = opcode ^ (^lock_address);

	// a stalled result word holds
	`LRHS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(lock_id) && $stable(status) && $stable(held_depth))

	// one item at a time: the block is busy right after taking a word
	`LRHS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// registry full and unknown lock carry no id
	`LRHS_ASSERT_NOW(a_zero_id, clk, arst_n, out_valid && (status == STAT_REG_FULL || status == STAT_UNKNOWN), lock_id == '0)

	// status codes and stack depth stay in range
	`LRHS_ASSERT_NOW(a_ranges, clk, arst_n, out_valid, status <= STAT_NOT_HELD && held_depth <= DEPTH_W'(MAX_HELD))

endmodule

bind lock_registry_held_stack lrhs_checker u_lrhs_checker (.*);

`default_nettype wire
